// ===== hdl/atd_pkg.sv =====
package atd_pkg;

  localparam int TEMP_W   = 8;
  localparam int TOTAL_W  = 12;
  localparam int TARGET_W = 7;
  localparam int BAND_W   = 4;
  localparam int LIM_W    = 13;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [TARGET_W-1:0] TARGET_RST = 7'd50;
  localparam logic [BAND_W-1:0]   BAND_RST   = 4'd5;

  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_BAND   = 1'b1;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               blink;
  } item_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [BAND_W-1:0]   band;
  } cfg_t;

  typedef struct packed {
    logic heater;
    logic cooler;
    logic led;
  } result_t;

endpackage

// ===== hdl/averaging_thermostat_deadband_core.sv =====
// A sample's running total is registered in the queue, then its result in the
// output register. Throughput: one sample per cycle while the queue has space;
// a two-entry queue decouples the ring/total front from the threshold compare.
// Reset (synchronous, rst_n low): ring, slot and total clear to zero, queue
// and output empty, target 50 and band 5.
module averaging_thermostat_deadband_core #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [atd_pkg::TEMP_W-1:0]   in_sample_temp,
  input  logic                         in_blink_phase,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_heater_on,
  output logic                         out_cooler_on,
  output logic                         out_indicator_led,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [atd_pkg::ADDR_W-1:0]   paddr,
  input  logic [atd_pkg::DATA_W-1:0]   pwdata,
  output logic [atd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  atd_pkg::cfg_t    cfg_r;
  atd_pkg::item_t   push_item;
  atd_pkg::item_t   pop_item;
  atd_pkg::result_t res;
  logic             push;
  logic             pop;
  logic             space;
  logic             avail;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= atd_pkg::TARGET_RST;
      cfg_r.band   <= atd_pkg::BAND_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        atd_pkg::REG_TARGET: cfg_r.target <= pwdata[atd_pkg::TARGET_W-1:0];
        atd_pkg::REG_BAND:   cfg_r.band   <= pwdata[atd_pkg::BAND_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      atd_pkg::REG_TARGET: prdata = atd_pkg::DATA_W'(cfg_r.target);
      atd_pkg::REG_BAND:   prdata = atd_pkg::DATA_W'(cfg_r.band);
    endcase
  end

  atd_front #(.WINDOW_LEN(WINDOW_LEN)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_temp (in_sample_temp),
    .in_blink_phase (in_blink_phase),
    .q_space        (space),
    .q_push         (push),
    .q_item         (push_item)
  );

  atd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .space     (space),
    .pop       (pop),
    .avail     (avail),
    .pop_item  (pop_item)
  );

  atd_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_avail   (avail),
    .q_item    (pop_item),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_heater_on     = res.heater;
  assign out_cooler_on     = res.cooler;
  assign out_indicator_led = res.led;

endmodule

// ===== hdl/atd_front.sv =====
module atd_front #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [atd_pkg::TEMP_W-1:0] in_sample_temp,
  input  logic                       in_blink_phase,
  input  logic                       q_space,
  output logic                       q_push,
  output atd_pkg::item_t             q_item
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);

  logic [atd_pkg::TEMP_W-1:0]  ring_r [WINDOW_LEN];
  logic [SLOT_W-1:0]           slot_r;
  logic [SLOT_W-1:0]           slot_nxt;
  logic [atd_pkg::TOTAL_W-1:0] total_r;
  logic [atd_pkg::TOTAL_W-1:0] total_nxt;

  assign in_ready = q_space;
  assign q_push   = in_valid && q_space;

  assign total_nxt = total_r - atd_pkg::TOTAL_W'(ring_r[slot_r])
                   + atd_pkg::TOTAL_W'(in_sample_temp);
  assign slot_nxt  = (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + 1'b1;

  assign q_item.total = total_nxt;
  assign q_item.blink = in_blink_phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        ring_r[k] <= '0;
      end
      slot_r  <= '0;
      total_r <= '0;
    end else if (q_push) begin
      ring_r[slot_r] <= in_sample_temp;
      slot_r         <= slot_nxt;
      total_r        <= total_nxt;
    end
  end

endmodule

// ===== hdl/atd_fifo.sv =====
module atd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  atd_pkg::item_t push_item,
  output logic           space,
  input  logic           pop,
  output logic           avail,
  output atd_pkg::item_t pop_item
);

  atd_pkg::item_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic [1:0]     cnt_nxt;

  assign space    = (cnt_r != 2'd2);
  assign avail    = (cnt_r != 2'd0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/atd_back.sv =====
module atd_back #(
  parameter int WINDOW_LEN = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  atd_pkg::cfg_t  cfg,
  input  logic           q_avail,
  input  atd_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output atd_pkg::result_t res
);

  logic [atd_pkg::TARGET_W:0]  lower;
  logic [atd_pkg::TARGET_W:0]  upper1;
  logic [atd_pkg::LIM_W-1:0]   lo_lim;
  logic [atd_pkg::LIM_W-1:0]   hi_lim;
  logic [atd_pkg::LIM_W-1:0]   total_ext;
  atd_pkg::result_t            res_nxt;
  atd_pkg::result_t            res_r;
  logic                        valid_r;

  assign lower  = {1'b0, cfg.target} - (atd_pkg::TARGET_W + 1)'(cfg.band);
  assign upper1 = {1'b0, cfg.target} + (atd_pkg::TARGET_W + 1)'(cfg.band)
                + (atd_pkg::TARGET_W + 1)'(1);

  assign lo_lim    = atd_pkg::LIM_W'(lower[atd_pkg::TARGET_W-1:0])
                   * atd_pkg::LIM_W'(WINDOW_LEN);
  assign hi_lim    = atd_pkg::LIM_W'(upper1) * atd_pkg::LIM_W'(WINDOW_LEN);
  assign total_ext = atd_pkg::LIM_W'(q_item.total);

  always_comb begin
    res_nxt = '0;
    priority if (!lower[atd_pkg::TARGET_W] && (total_ext < lo_lim)) begin
      res_nxt.heater = 1'b1;
      res_nxt.led    = q_item.blink;
    end else if (total_ext >= hi_lim) begin
      res_nxt.cooler = 1'b1;
      res_nxt.led    = 1'b1;
    end else begin
      res_nxt = '0;
    end
  end

  assign q_pop     = q_avail && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

endmodule

// ===== hdl/atd_checker.sv =====
module atd_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_heater_on,
  input logic out_cooler_on,
  input logic out_indicator_led
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable({out_heater_on, out_cooler_on, out_indicator_led}))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_heater_on && out_cooler_on))
    else $error("heater and cooler both on");

  a_led_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_heater_on && !out_cooler_on |-> !out_indicator_led)
    else $error("led on inside dead band");

  a_led_cool: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cooler_on |-> out_indicator_led)
    else $error("led off while cooling");

endmodule

bind averaging_thermostat_deadband_core atd_checker u_atd_checker (.*);
